// ===== rtl/core/fvc_pkg.sv =====
package fvc_pkg;

  // fixed-point formats
  localparam int FIELD_FRAC_BITS = 30;
  localparam int VOLT_FRAC_BITS  = 16;
  localparam int COEF_FRAC       = 32;

  localparam int FIELD_W  = 32;
  localparam int OUT_W    = 32;
  localparam int SYS_W    = 3;
  localparam int N_SETS   = 5;
  localparam int N_ORDERS = 6;

  // accumulator holds +-(2^62 - 1) with 32 fraction bits
  localparam int ACC_W  = 63;
  localparam int MAG_W  = ACC_W - 1;
  localparam int HALF_W = MAG_W / 2;
  localparam int PP_W   = HALF_W + FIELD_W;
  localparam int PROD_W = MAG_W + FIELD_W;
  localparam int COEF_W = 56;

  localparam logic [MAG_W-1:0] ACC_LIMIT = {MAG_W{1'b1}};

  // calibration values in millionths, laid out as [set][positive field][order]
  localparam longint unsigned MICRO = 64'd1000000;
  localparam int TAB_N     = N_SETS * 2 * N_ORDERS;
  localparam int TAB_IDX_W = $clog2(TAB_N);

  localparam longint COEF_MICRO [TAB_N] = '{
    64'sd117150, 64'sd22279000, -64'sd290910000, -64'sd1628100000,
    -64'sd9748700000, 64'sd0,
    -64'sd123240, 64'sd23449000, 64'sd260630000, -64'sd1374700000,
    64'sd9139400000, 64'sd0,
    64'sd57656, 64'sd27008000, 64'sd127070000, 64'sd750060000,
    64'sd681100000, 64'sd0,
    -64'sd39495, 64'sd26633000, -64'sd120350000, 64'sd708730000,
    -64'sd597460000, 64'sd0,
    64'sd281110, 64'sd52044000, -64'sd275900000, -64'sd3273000000,
    -64'sd17333000000, 64'sd0,
    -64'sd261070, 64'sd51317000, 64'sd294140000, -64'sd3473700000,
    64'sd18007000000, 64'sd0,
    64'sd28303, 64'sd21947000, -64'sd19750000, -64'sd683410000,
    -64'sd5157300000, -64'sd8295400000,
    -64'sd15566, 64'sd21992000, 64'sd16435000, -64'sd628420000,
    64'sd4843200000, -64'sd7762300000,
    64'sd65600, 64'sd190080000, 64'sd5931600000, 64'sd251190000000,
    64'sd1501600000000, 64'sd0,
    -64'sd268530, 64'sd250560000, -64'sd10775000000, 64'sd399110000000,
    -64'sd3095000000000, 64'sd0
  };

  localparam longint FALLBACK_MICRO = 64'sd1100000;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [TAB_N-1:0][COEF_W-1:0] coef_tab_t;

  // millionths to Q.32, nearest with ties away from zero (elaboration only)
  function automatic logic [COEF_W-1:0] micro_to_q32(input longint v);
    logic neg;
    longint unsigned m;
    longint unsigned ip;
    longint unsigned fp;
    longint unsigned q;
    neg = (v < 0);
    m   = neg ? longint'(-v) : longint'(v);
    ip  = m / MICRO;
    fp  = m % MICRO;
    q   = (ip << COEF_FRAC) + ((fp << COEF_FRAC) + MICRO / 2) / MICRO;
    return neg ? COEF_W'(64'd0 - q) : COEF_W'(q);
  endfunction

  function automatic coef_tab_t build_coef_tab();
    coef_tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = micro_to_q32(COEF_MICRO[i]);
    end
    return t;
  endfunction

  localparam coef_tab_t COEF_Q32 = build_coef_tab();
  localparam logic [COEF_W-1:0] FALLBACK_Q32 = micro_to_q32(FALLBACK_MICRO);

  // coefficient of one order for the set and field sign, or the fallback
  function automatic coef_t coef_sel(input logic [SYS_W-1:0] sys, input logic pos,
                                     input int order);
    logic [TAB_IDX_W-1:0] idx;
    coef_t k;
    idx = TAB_IDX_W'((int'(sys) * 2 + int'(pos)) * N_ORDERS + order);
    if (sys < SYS_W'(N_SETS)) begin
      k = signed'(COEF_Q32[idx]);
    end else if (order < N_ORDERS - 1) begin
      k = signed'(FALLBACK_Q32);
    end else begin
      k = '0;
    end
    return k;
  endfunction

  // one conversion as it travels along the chain
  typedef struct packed {
    logic                     zero;
    logic                     pos;
    logic [SYS_W-1:0]         sys;
    logic signed [FIELD_W-1:0] x;
    logic signed [ACC_W-1:0]  acc;
    logic                     sat;
  } item_t;

endpackage

// ===== rtl/core/field_to_voltage_calibration_core.sv =====
// Field set-point to drive voltage conversion with a fifth-order calibration
// polynomial, evaluated in Horner form along a chain of five cells.
//
// Input: a set-point is taken at each rising edge with start high and busy
// low. busy stays low, so a new set-point may be given in every cycle.
// Output: done_o is high for one cycle with drive_voltage_o and saturated_o.
// The receiver cannot stall and no result is held back.
// Pipeline: one input register, three stages in each of the five Horner
// cells and one output rounding register carry each set-point to the
// output. Throughput: one set-point per clock cycle. Each cell splits
// its 62 x 32 bit product into two partial products, which sets the
// three stages per cell.
// Configuration: magnet_system_i is written when cfg_valid_i is high
// (cfg_ready_o is always high); the set is sampled with each set-point,
// so a write affects only later set-points.
// Reset: clears the pipeline valid bits and sets the calibration set to 0;
// no result is produced until a new set-point arrives.
module field_to_voltage_calibration_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [fvc_pkg::FIELD_W-1:0]   field_setpoint_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fvc_pkg::SYS_W-1:0]            magnet_system_i,
  output logic                                 done_o,
  output logic signed [fvc_pkg::OUT_W-1:0]     drive_voltage_o,
  output logic                                 saturated_o
);

  localparam int N_CELLS = fvc_pkg::N_ORDERS - 1;
  localparam int ACC_W   = fvc_pkg::ACC_W;
  localparam int CW      = fvc_pkg::COEF_W;
  localparam int FW      = fvc_pkg::FIELD_W;

  logic [fvc_pkg::SYS_W-1:0] magnet_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magnet_q <= '0;
    end else if (cfg_valid_i) begin
      magnet_q <= magnet_system_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // input register: classify the field and load the top coefficient
  logic           in_vld_q;
  fvc_pkg::item_t in_q, in_d;
  fvc_pkg::coef_t k_top;

  always_comb begin
    in_d.x    = field_setpoint_i;
    in_d.zero = (field_setpoint_i == '0);
    in_d.pos  = !field_setpoint_i[FW-1] && !in_d.zero;
    in_d.sys  = magnet_q;
    in_d.sat  = 1'b0;
    k_top     = fvc_pkg::coef_sel(magnet_q, in_d.pos, fvc_pkg::N_ORDERS - 1);
    in_d.acc  = {{(ACC_W - CW){k_top[CW-1]}}, k_top};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  // Horner chain, highest order first
  logic           vld [N_CELLS+1];
  fvc_pkg::item_t itm [N_CELLS+1];

  assign vld[0] = in_vld_q;
  assign itm[0] = in_q;

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    fvc_cell #(
      .ORDER (N_CELLS - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .item_i  (itm[g]),
      .valid_o (vld[g+1]),
      .item_o  (itm[g+1])
    );
  end

  // output rounding and saturation
  fvc_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[N_CELLS]),
    .item_i  (itm[N_CELLS]),
    .valid_o (done_o),
    .volt_o  (drive_voltage_o),
    .sat_o   (saturated_o)
  );

  // every accepted set-point gives one result at the output
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##17 done_o)
    else $error("accepted set-point gave no result");

  // no result without a set-point at the matching earlier edge
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, 17))
    else $error("result without a set-point");

  // a zero field gives zero volts and no saturation
  a_zero_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(field_setpoint_i == '0, 17)) |->
      (drive_voltage_o == '0 && !saturated_o))
    else $error("zero field did not give zero volts");

  // a saturated result sits at one of the limits
  a_sat_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (drive_voltage_o == 32'sh7FFFFFFF || drive_voltage_o == 32'sh80000000))
    else $error("saturated result off the limits");

endmodule

// ===== rtl/core/fvc_cell.sv =====
module fvc_cell #(
  parameter int ORDER = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  fvc_pkg::item_t item_i,
  output logic          valid_o,
  output fvc_pkg::item_t item_o
);

  localparam int ACC_W  = fvc_pkg::ACC_W;
  localparam int MAG_W  = fvc_pkg::MAG_W;
  localparam int HALF_W = fvc_pkg::HALF_W;
  localparam int PP_W   = fvc_pkg::PP_W;
  localparam int PROD_W = fvc_pkg::PROD_W;
  localparam int FW     = fvc_pkg::FIELD_W;
  localparam int CW     = fvc_pkg::COEF_W;
  localparam int FRAC   = fvc_pkg::FIELD_FRAC_BITS;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W:0] SUM_MAX = {2'b00, fvc_pkg::ACC_LIMIT};
  localparam logic signed [ACC_W:0] SUM_MIN = -SUM_MAX;

  logic [2:0] vld_q;

  fvc_pkg::item_t s1_q, s2_q, s3_q;
  logic [PP_W-1:0]  pp_lo_q, pp_lo_d, pp_hi_q, pp_hi_d;
  logic             neg1_q, neg1_d, neg2_q;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic             over_d;
  fvc_pkg::item_t   s2_d;
  fvc_pkg::item_t   s3_d;

  // stage 1: magnitudes and two partial products
  logic signed [ACC_W-1:0] acc_neg;
  logic [MAG_W-1:0]        am;
  logic [FW-1:0]           xm;

  always_comb begin
    acc_neg = -item_i.acc;
    am      = item_i.acc[ACC_W-1] ? acc_neg[MAG_W-1:0] : item_i.acc[MAG_W-1:0];
    xm      = item_i.x[FW-1] ? (FW'(0) - item_i.x) : item_i.x;
    neg1_d  = item_i.acc[ACC_W-1] ^ item_i.x[FW-1];
    pp_lo_d = PP_W'(am[HALF_W-1:0]) * PP_W'(xm);
    pp_hi_d = PP_W'(am[MAG_W-1:HALF_W]) * PP_W'(xm);
  end

  // stage 2: combine, round, scale and bound the magnitude
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] scaled;

  always_comb begin
    prod   = PROD_W'(pp_lo_q) + (PROD_W'(pp_hi_q) << HALF_W) + ROUND_HALF;
    scaled = prod >> FRAC;
    over_d = scaled > PROD_W'(fvc_pkg::ACC_LIMIT);
    mag_d  = over_d ? fvc_pkg::ACC_LIMIT : scaled[MAG_W-1:0];
    s2_d     = s1_q;
    s2_d.sat = s1_q.sat | over_d;
  end

  // stage 3: restore sign, add this order's coefficient, bound
  fvc_pkg::coef_t          k;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W:0]   sum;

  always_comb begin
    k    = fvc_pkg::coef_sel(s2_q.sys, s2_q.pos, ORDER);
    term = neg2_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    sum  = {term[ACC_W-1], term} + {{(ACC_W + 1 - CW){k[CW-1]}}, k};
    s3_d = s2_q;
    if (sum > SUM_MAX) begin
      s3_d.acc = SUM_MAX[ACC_W-1:0];
      s3_d.sat = 1'b1;
    end else if (sum < SUM_MIN) begin
      s3_d.acc = SUM_MIN[ACC_W-1:0];
      s3_d.sat = 1'b1;
    end else begin
      s3_d.acc = sum[ACC_W-1:0];
    end
  end

  // valid shift along the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    s1_q    <= item_i;
    pp_lo_q <= pp_lo_d;
    pp_hi_q <= pp_hi_d;
    neg1_q  <= neg1_d;
    s2_q    <= s2_d;
    mag_q   <= mag_d;
    neg2_q  <= neg1_q;
    s3_q    <= s3_d;
  end

  assign valid_o = vld_q[2];
  assign item_o  = s3_q;

endmodule

// ===== rtl/core/fvc_round.sv =====
module fvc_round (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  fvc_pkg::item_t                      item_i,
  output logic                                valid_o,
  output logic signed [fvc_pkg::OUT_W-1:0]    volt_o,
  output logic                                sat_o
);

  localparam int ACC_W = fvc_pkg::ACC_W;
  localparam int MAG_W = fvc_pkg::MAG_W;
  localparam int OUT_W = fvc_pkg::OUT_W;
  localparam int SH    = fvc_pkg::COEF_FRAC - fvc_pkg::VOLT_FRAC_BITS;
  localparam int R_W   = ACC_W - SH;
  localparam logic [ACC_W-1:0] HALF_LSB  = ACC_W'(1) << (SH - 1);
  localparam logic [R_W-1:0]   R_POS_MAX = R_W'({1'b0, {(OUT_W - 1){1'b1}}});
  localparam logic [R_W-1:0]   R_NEG_MAX = R_W'({1'b1, {(OUT_W - 1){1'b0}}});
  localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_MAX = {1'b1, {(OUT_W - 1){1'b0}}};

  logic                   valid_q;
  logic [OUT_W-1:0]       volt_q, volt_d;
  logic                   sat_q, sat_d;

  logic                   neg;
  logic signed [ACC_W-1:0] acc_neg;
  logic [MAG_W-1:0]       m;
  logic [ACC_W-1:0]       m_rnd;
  logic [R_W-1:0]         r;

  // round to the output fraction, then clamp to the output range
  always_comb begin
    neg     = item_i.acc[ACC_W-1];
    acc_neg = -item_i.acc;
    m       = neg ? acc_neg[MAG_W-1:0] : item_i.acc[MAG_W-1:0];
    m_rnd   = {1'b0, m} + HALF_LSB;
    r       = m_rnd[ACC_W-1:SH];
    volt_d  = '0;
    sat_d   = 1'b0;
    if (item_i.zero) begin
      volt_d = '0;
      sat_d  = 1'b0;
    end else if (!neg && (item_i.sat || r > R_POS_MAX)) begin
      volt_d = OUT_POS_MAX;
      sat_d  = 1'b1;
    end else if (neg && (item_i.sat || r > R_NEG_MAX)) begin
      volt_d = OUT_NEG_MAX;
      sat_d  = 1'b1;
    end else begin
      volt_d = neg ? (OUT_W'(0) - r[OUT_W-1:0]) : r[OUT_W-1:0];
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    volt_q <= volt_d;
    sat_q  <= sat_d;
  end

  assign valid_o = valid_q;
  assign volt_o  = volt_q;
  assign sat_o   = sat_q;

endmodule
